[rtl/core/psm_pkg.sv]
// Shared constants, codes and controller-to-datapath types for the sample mixer.
package psm_pkg;

   localparam int NUM_VOICES       = 4;
   localparam int NUM_SAMPLE_SLOTS = 8;
   localparam int SAMPLE_MEM_WORDS = 65536;

   localparam int VOICE_AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int SLOT_AW  = (NUM_SAMPLE_SLOTS > 1) ? $clog2(NUM_SAMPLE_SLOTS) : 1;
   localparam int MEM_AW   = $clog2(SAMPLE_MEM_WORDS);
   localparam int CNT_W    = $clog2(NUM_VOICES + 1);
   localparam int SUM_W    = 16 + $clog2(NUM_VOICES);

   localparam logic [16:0] MAX_LEN = 17'd65536;
   localparam logic signed [SUM_W-1:0] AUDIO_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] AUDIO_MIN = -SUM_W'(32768);

   typedef logic [MEM_AW-1:0] mem_addr_type;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_DEFINE  = 2'd1,
      REQ_TRIGGER = 2'd2,
      REQ_TICK    = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                latch_req;
      logic                exec_op;
      logic                tick_issue;
      logic [VOICE_AW-1:0] tick_voice;
      logic                load_rsp;
   } cmd_type;

endpackage

[rtl/core/polyphonic_sample_mixer.sv]
// Polyphonic one-shot sample player with a four-voice mixer and voice stealing.
// Every request word yields exactly one response word. A write, define or trigger
// executes once and then loads its response; a tick walks the voices through the
// single read port of the sample memory, which serves one voice per cycle, then
// accumulates the registered read data before the result is loaded. Ready returns
// in the cycle after the result is loaded. One request is in flight at a time; a
// new request is accepted once the previous one is handed to the output register,
// even while that response still waits for rsp_ready. The attenuation shift resets
// to 1 and is written through csr_wr_en; the user must write it only while idle,
// since the block itself does not enforce that. Sample memory and descriptors are
// not cleared by reset; loaded flags and voices are.
module polyphonic_sample_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_word_address,
   input  logic signed [15:0] req_pcm_word,
   input  logic [2:0]         req_sample_id,
   input  logic [16:0]        req_sample_words,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_audio_out,
   output logic               rsp_status,
   output logic [1:0]         rsp_voice_slot,
   output logic [2:0]         rsp_active_voices
);
   import psm_pkg::*;

   cmd_type cmd;

   psm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   psm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_type          (req_type),
      .req_word_address  (req_word_address),
      .req_pcm_word      (req_pcm_word),
      .req_sample_id     (req_sample_id),
      .req_sample_words  (req_sample_words),
      .rsp_audio_out     (rsp_audio_out),
      .rsp_status        (rsp_status),
      .rsp_voice_slot    (rsp_voice_slot),
      .rsp_active_voices (rsp_active_voices)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_voice_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_active_voices) <= NUM_VOICES))
      else $error("active voice count exceeds voice count");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_voice_slot == 2'd0 && rsp_audio_out == 16'sd0))
      else $error("skipped trigger carries slot or audio");

   a_slot_no_audio: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_voice_slot != 2'd0) |-> (rsp_audio_out == 16'sd0))
      else $error("trigger response carries audio");
`endif

endmodule

[rtl/core/psm_ctrl.sv]
// Sequencer for the sample mixer: request intake, voice walk on a tick, result handoff.
module psm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psm_pkg::cmd_type  cmd
);
   import psm_pkg::*;

   state_type           state_ff, state_in;
   logic [VOICE_AW-1:0] voice_ff, voice_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         voice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voice_ff     <= voice_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      voice_in       = voice_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.tick_voice = voice_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               voice_in      = '0;
               state_in      = (req_op_type'(req_type) == REQ_TICK) ? ST_TICK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec_op = 1'b1;
            state_in    = ST_DONE;
         end
         ST_TICK: begin
            // one voice per cycle through the single memory read port
            cmd.tick_issue = 1'b1;
            if (int'(voice_ff) == NUM_VOICES - 1) begin
               state_in = ST_DRAIN;
            end else begin
               voice_in = voice_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/psm_datapath.sv]
// Sample memory, descriptor table, voice registers, mixer accumulator and result word.
module psm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  psm_pkg::cmd_type    cmd,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data,
   input  logic [1:0]          req_type,
   input  logic [15:0]         req_word_address,
   input  logic signed [15:0]  req_pcm_word,
   input  logic [2:0]          req_sample_id,
   input  logic [16:0]         req_sample_words,
   output logic signed [15:0]  rsp_audio_out,
   output logic                rsp_status,
   output logic [1:0]          rsp_voice_slot,
   output logic [2:0]          rsp_active_voices
);
   import psm_pkg::*;

   logic [1:0]        atten_ff;
   req_op_type        op_ff;
   logic [15:0]       addr_ff;
   logic [15:0]       pcm_ff;
   logic [2:0]        id_ff;
   logic [16:0]       words_ff;

   logic [15:0]       mem [SAMPLE_MEM_WORDS];
   logic [15:0]       rd_q_ff;
   mem_addr_type      rd_addr;
   logic              mem_we;

   logic [15:0]       start_ff  [NUM_SAMPLE_SLOTS];
   logic [16:0]       length_ff [NUM_SAMPLE_SLOTS];
   logic [NUM_SAMPLE_SLOTS-1:0] loaded_ff;
   logic [SLOT_AW-1:0] id_idx;
   logic              id_ok;

   logic [15:0]       vaddr_ff [NUM_VOICES];
   logic [15:0]       vaddr_in [NUM_VOICES];
   logic [16:0]       vrem_ff  [NUM_VOICES];
   logic [16:0]       vrem_in  [NUM_VOICES];
   logic [NUM_VOICES-1:0] vact_ff, vact_in;

   logic              rd_pend_ff, rd_pend_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic              skip_ff, skip_in;
   logic [VOICE_AW-1:0] slot_ff, slot_in;

   logic signed [SUM_W-1:0] shifted;
   logic signed [15:0] audio_sat;
   logic [CNT_W-1:0]  act_cnt;

   assign id_idx = SLOT_AW'(id_ff);
   assign id_ok  = (int'(id_ff) < NUM_SAMPLE_SLOTS) && loaded_ff[id_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         atten_ff <= 2'd1;
      end else if (csr_wr_en) begin
         atten_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req_op_type'(req_type);
         addr_ff  <= req_word_address;
         pcm_ff   <= req_pcm_word;
         id_ff    <= req_sample_id;
         words_ff <= req_sample_words;
      end
   end

   // sample memory: one write port, one registered read port
   assign mem_we  = cmd.exec_op && (op_ff == REQ_WRITE);
   assign rd_addr = mem_addr_type'(vaddr_ff[cmd.tick_voice]);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr_type'(addr_ff)] <= pcm_ff;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // descriptor table
   always_ff @(posedge clock) begin
      if (cmd.exec_op && op_ff == REQ_DEFINE && int'(id_ff) < NUM_SAMPLE_SLOTS) begin
         start_ff[id_idx]  <= addr_ff;
         length_ff[id_idx] <= (words_ff > MAX_LEN) ? MAX_LEN : words_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (cmd.exec_op && op_ff == REQ_DEFINE && int'(id_ff) < NUM_SAMPLE_SLOTS) begin
         loaded_ff[id_idx] <= 1'b1;
      end
   end

   // voice update for trigger and tick
   always_comb begin
      logic                found;
      logic [VOICE_AW-1:0] pick;
      found      = 1'b0;
      pick       = '0;
      vaddr_in   = vaddr_ff;
      vrem_in    = vrem_ff;
      vact_in    = vact_ff;
      rd_pend_in = 1'b0;
      skip_in    = skip_ff;
      slot_in    = slot_ff;
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (!found && !vact_ff[i]) begin
            found = 1'b1;
            pick  = VOICE_AW'(i);
         end
      end
      if (cmd.latch_req) begin
         skip_in = 1'b0;
         slot_in = '0;
      end
      if (cmd.exec_op && op_ff == REQ_TRIGGER) begin
         if (!id_ok) begin
            skip_in = 1'b1;
         end else begin
            // steal voice 0 when every voice is busy
            vaddr_in[pick] = start_ff[id_idx];
            vrem_in[pick]  = length_ff[id_idx];
            vact_in[pick]  = 1'b1;
            slot_in        = pick;
         end
      end
      if (cmd.tick_issue && vact_ff[cmd.tick_voice]) begin
         if (vrem_ff[cmd.tick_voice] == '0) begin
            vact_in[cmd.tick_voice] = 1'b0;
         end else begin
            rd_pend_in = 1'b1;
            vaddr_in[cmd.tick_voice] = vaddr_ff[cmd.tick_voice] + 16'd1;
            vrem_in[cmd.tick_voice]  = vrem_ff[cmd.tick_voice] - 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            vaddr_ff[i] <= '0;
            vrem_ff[i]  <= '0;
         end
         vact_ff    <= '0;
         rd_pend_ff <= 1'b0;
         skip_ff    <= 1'b0;
         slot_ff    <= '0;
      end else begin
         vaddr_ff   <= vaddr_in;
         vrem_ff    <= vrem_in;
         vact_ff    <= vact_in;
         rd_pend_ff <= rd_pend_in;
         skip_ff    <= skip_in;
         slot_ff    <= slot_in;
      end
   end

   // accumulate the word read in the previous cycle
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         sum_ff <= '0;
      end else if (rd_pend_ff) begin
         sum_ff <= sum_ff + SUM_W'(signed'(rd_q_ff));
      end
   end

   always_comb begin
      shifted = sum_ff >>> atten_ff;
      if (shifted > AUDIO_MAX) begin
         audio_sat = 16'sh7fff;
      end else if (shifted < AUDIO_MIN) begin
         audio_sat = -16'sh8000;
      end else begin
         audio_sat = shifted[15:0];
      end
      act_cnt = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         act_cnt = act_cnt + CNT_W'(vact_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_audio_out     <= (op_ff == REQ_TICK) ? audio_sat : 16'sd0;
         rsp_status        <= skip_ff;
         rsp_voice_slot    <= 2'(slot_ff);
         rsp_active_voices <= 3'(act_cnt);
      end
   end

endmodule

[sim/mixer_checker.sv]
// Response checker for the sample mixer: mirrors memory, descriptors and voices, compares words.
`timescale 1ns / 1ps
module mixer_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [1:0]                              csr_wr_data,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic [1:0]                              req_type,
   input  logic [15:0]                             req_word_address,
   input  logic [15:0]                             req_pcm_word,
   input  logic [2:0]                              req_sample_id,
   input  logic [16:0]                             req_sample_words,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [15:0]                      rsp_audio_out,
   input  logic                                    rsp_status,
   input  logic [1:0]                              rsp_voice_slot,
   input  logic [2:0]                              rsp_active_voices,
   output int unsigned                             fail_count,
   output int unsigned                             pending_results,
   output logic [psm_pkg::NUM_VOICES-1:0]          voice_reads,
   output logic [psm_pkg::NUM_VOICES-1:0][15:0]    voice_next_addr
);
   import psm_pkg::*;

   typedef struct packed {
      logic [15:0] audio;
      logic        status;
      logic [1:0]  slot;
      logic [2:0]  voices;
   } mix_word_type;

   mix_word_type expected_mixes[$];
   mix_word_type got_mix;
   mix_word_type want_mix;

   logic [1:0]  atten_shift;
   logic [15:0] pcm_mem [SAMPLE_MEM_WORDS];
   logic [15:0] slot_start [NUM_SAMPLE_SLOTS];
   logic [16:0] slot_len [NUM_SAMPLE_SLOTS];
   logic [NUM_SAMPLE_SLOTS-1:0] slot_loaded;
   logic [15:0] v_addr [NUM_VOICES];
   logic [16:0] v_left [NUM_VOICES];
   logic [NUM_VOICES-1:0] v_on;

   // Apply one request word to the mirrored state and return the response it should produce.
   function automatic mix_word_type mix_request(req_op_type op, logic [15:0] addr,
                                                logic [15:0] pcm, logic [2:0] id,
                                                logic [16:0] words);
      mix_word_type r;
      int        sum;
      int        v;
      int        pick;
      r = '0;
      case (op)
         REQ_WRITE: begin
            pcm_mem[addr] = pcm;
         end
         REQ_DEFINE: begin
            if (id < NUM_SAMPLE_SLOTS) begin
               slot_start[id]  = addr;
               slot_len[id]    = (words > MAX_LEN) ? MAX_LEN : words;
               slot_loaded[id] = 1'b1;
            end
         end
         REQ_TRIGGER: begin
            if (id >= NUM_SAMPLE_SLOTS || !slot_loaded[id]) begin
               r.status = 1'b1;
            end else begin
               // lowest idle voice wins; steal voice 0 when all are busy
               pick = 0;
               for (v = NUM_VOICES - 1; v >= 0; v--)
                  if (!v_on[v]) pick = v;
               v_addr[pick] = slot_start[id];
               v_left[pick] = slot_len[id];
               v_on[pick]   = 1'b1;
               r.slot       = pick[1:0];
            end
         end
         default: begin
            sum = 0;
            for (v = 0; v < NUM_VOICES; v++) begin
               if (v_on[v]) begin
                  if (v_left[v] == 0) begin
                     v_on[v] = 1'b0;
                  end else begin
                     sum = sum + $signed(pcm_mem[v_addr[v]]);
                     v_addr[v] = v_addr[v] + 16'd1;
                     v_left[v] = v_left[v] - 17'd1;
                  end
               end
            end
            sum = sum >>> atten_shift;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            r.audio = sum[15:0];
         end
      endcase
      r.voices = 3'($countones(v_on));
      return r;
   endfunction

   task automatic compare_field(string field, logic signed [16:0] want, logic signed [16:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         atten_shift = 2'd1;
         slot_loaded = '0;
         v_on        = '0;
         fail_count  = 0;
         for (int v = 0; v < NUM_VOICES; v++) begin
            v_addr[v] = '0;
            v_left[v] = '0;
         end
         expected_mixes.delete();
      end else begin
         if (csr_wr_en) atten_shift = csr_wr_data;
         // retire the response first so a word accepted on the same edge queues behind it
         if (rsp_valid && rsp_ready) begin
            got_mix = {rsp_audio_out, rsp_status, rsp_voice_slot, rsp_active_voices};
            if (expected_mixes.size() == 0) begin
               $display("%0t: unexpected response word, audio %0d status %0d slot %0d voices %0d",
                        $time, rsp_audio_out, rsp_status, rsp_voice_slot, rsp_active_voices);
               fail_count++;
            end else begin
               want_mix = expected_mixes.pop_front();
               compare_field("audio_out", 17'($signed(want_mix.audio)),
                             17'($signed(got_mix.audio)));
               compare_field("status", 17'(want_mix.status), 17'(got_mix.status));
               compare_field("voice_slot", 17'(want_mix.slot), 17'(got_mix.slot));
               compare_field("active_voices", 17'(want_mix.voices), 17'(got_mix.voices));
            end
         end
         if (req_valid && req_ready)
            expected_mixes.push_back(mix_request(req_op_type'(req_type), req_word_address,
                                                 req_pcm_word, req_sample_id,
                                                 req_sample_words));
      end
      pending_results <= expected_mixes.size();
      for (int v = 0; v < NUM_VOICES; v++) begin
         voice_reads[v]     <= v_on[v] && (v_left[v] != 0);
         voice_next_addr[v] <= v_addr[v];
      end
   end

endmodule

[sim/polyphonic_sample_mixer_tb.sv]
// Testbench top for the sample mixer: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps
module polyphonic_sample_mixer_tb;
   import psm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          PHASE_WORDS = 150;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic [15:0]        req_word_address;
   logic signed [15:0] req_pcm_word;
   logic [2:0]         req_sample_id;
   logic [16:0]        req_sample_words;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_audio_out;
   logic               rsp_status;
   logic [1:0]         rsp_voice_slot;
   logic [2:0]         rsp_active_voices;

   int unsigned                 fail_count;
   int unsigned                 pending_results;
   logic [NUM_VOICES-1:0]       voice_reads;
   logic [NUM_VOICES-1:0][15:0] voice_next_addr;

   bit          written [SAMPLE_MEM_WORDS];
   bit          steady;
   int unsigned stall_left = 0;
   int unsigned cycles = 0;
   int unsigned sent_writes, sent_defines, sent_triggers, sent_ticks;
   logic [1:0]  shift_plan [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

   polyphonic_sample_mixer u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_word_address  (req_word_address),
      .req_pcm_word      (req_pcm_word),
      .req_sample_id     (req_sample_id),
      .req_sample_words  (req_sample_words),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_audio_out     (rsp_audio_out),
      .rsp_status        (rsp_status),
      .rsp_voice_slot    (rsp_voice_slot),
      .rsp_active_voices (rsp_active_voices)
   );

   mixer_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_word_address  (req_word_address),
      .req_pcm_word      (req_pcm_word),
      .req_sample_id     (req_sample_id),
      .req_sample_words  (req_sample_words),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_audio_out     (rsp_audio_out),
      .rsp_status        (rsp_status),
      .rsp_voice_slot    (rsp_voice_slot),
      .rsp_active_voices (rsp_active_voices),
      .fail_count        (fail_count),
      .pending_results   (pending_results),
      .voice_reads       (voice_reads),
      .voice_next_addr   (voice_next_addr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none at all in steady stretches.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (steady) return 0;
      if (roll < 10) return 0;
      if (roll < 17) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
      end
   end

   // Present one word and hold it until accepted; valid stays up for a back-to-back word.
   task automatic send_word(req_op_type op, logic [15:0] addr, logic [15:0] pcm,
                            logic [2:0] id, logic [16:0] words);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= op;
      req_word_address <= addr;
      req_pcm_word     <= pcm;
      req_sample_id    <= id;
      req_sample_words <= words;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      case (op)
         REQ_WRITE: begin
            written[addr] = 1'b1;
            sent_writes++;
         end
         REQ_DEFINE:  sent_defines++;
         REQ_TRIGGER: sent_triggers++;
         default:     sent_ticks++;
      endcase
   endtask

   // Fill any word a playing voice is about to read, then tick.
   task automatic send_tick();
      for (int v = 0; v < NUM_VOICES; v++)
         if (voice_reads[v] && !written[voice_next_addr[v]])
            send_word(REQ_WRITE, voice_next_addr[v], 16'($urandom()), 3'($urandom()),
                      17'($urandom()));
      send_word(REQ_TICK, 16'($urandom()), 16'($urandom()), 3'($urandom()), 17'($urandom()));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
   endtask

   task automatic set_attenuation(logic [1:0] shift);
      drain_results();
      repeat (10) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= shift;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_word();
      int unsigned roll;
      logic [16:0] len;
      logic [15:0] addr;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         send_tick();
      end else if (roll < 70) begin
         send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'($urandom_range(0, 7)),
                   17'($urandom()));
      end else if (roll < 85) begin
         addr = 16'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 300));
         send_word(REQ_WRITE, addr, 16'($urandom()), 3'($urandom()), 17'($urandom()));
      end else begin
         // long samples are rare: they hold a voice for a long time
         len  = 17'(($urandom_range(0, 39) == 0) ? $urandom_range(65536, 131071)
                                                 : $urandom_range(0, 24));
         addr = 16'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 280));
         send_word(REQ_DEFINE, addr, 16'($urandom()), 3'($urandom_range(0, 7)), len);
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_type         = REQ_WRITE;
      req_word_address = '0;
      req_pcm_word     = '0;
      req_sample_id    = '0;
      req_sample_words = '0;
      steady           = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // nothing loaded yet, no voices playing
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd3, 17'($urandom()));
      send_tick();
      send_word(REQ_WRITE, 16'd0, 16'h7FFF, 3'($urandom()), 17'($urandom()));
      send_word(REQ_WRITE, 16'd1, 16'h7FFF, 3'($urandom()), 17'($urandom()));
      send_word(REQ_WRITE, 16'd2, 16'h8000, 3'($urandom()), 17'($urandom()));
      send_word(REQ_WRITE, 16'd3, 16'h8000, 3'($urandom()), 17'($urandom()));
      send_word(REQ_WRITE, 16'hFFFE, 16'd100, 3'($urandom()), 17'($urandom()));
      send_word(REQ_WRITE, 16'hFFFF, 16'hFFFF, 3'($urandom()), 17'($urandom()));
      send_word(REQ_DEFINE, 16'd0, 16'($urandom()), 3'd0, 17'd4);
      send_word(REQ_DEFINE, 16'hFFFE, 16'($urandom()), 3'd7, 17'd4);
      send_word(REQ_DEFINE, 16'd0, 16'($urandom()), 3'd1, 17'd0);
      send_word(REQ_DEFINE, 16'd2, 16'($urandom()), 3'd2, 17'h1FFFF);
      send_word(REQ_DEFINE, 16'd0, 16'($urandom()), 3'd5, 17'd65536);
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd0, 17'($urandom()));
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd7, 17'($urandom()));
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd1, 17'($urandom()));
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd0, 17'($urandom()));
      // all four busy: this one steals voice 0
      send_word(REQ_TRIGGER, 16'($urandom()), 16'($urandom()), 3'd2, 17'($urandom()));
      repeat (4) send_tick();
      send_word(REQ_DEFINE, 16'd0, 16'($urandom()), 3'd2, 17'd3);
      send_word(REQ_DEFINE, 16'd1, 16'($urandom()), 3'd5, 17'd2);
      send_tick();

      for (int p = 0; p < 4; p++) begin
         set_attenuation(shift_plan[p]);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            steady = (i >= 60 && i < 90);
            if ($urandom_range(0, 59) == 0) drain_results();
            random_word();
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (20) @(negedge clock);
      $display("Covered %0d writes, %0d defines, %0d triggers and %0d ticks",
               sent_writes, sent_defines, sent_triggers, sent_ticks);
      $display("with attenuation shifts 1, 0, 3, 2 and 1 under random stalls on both sides");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[polyphonic_sample_mixer.f]
rtl/core/psm_pkg.sv
rtl/core/psm_ctrl.sv
rtl/core/psm_datapath.sv
rtl/core/polyphonic_sample_mixer.sv
sim/mixer_checker.sv
sim/polyphonic_sample_mixer_tb.sv
